// File: rtl/utt_pkg.sv
// ----------------------------------------------------------------------------
// utt_pkg
// Shared types, constants and encoding helpers for the UTF-16 to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package utt_pkg;

	localparam int unsigned UTT_JOB_DEPTH = 4;

	localparam logic [15:0] UTT_HI_FIRST  = 16'hD800;
	localparam logic [15:0] UTT_HI_LAST   = 16'hDBFF;
	localparam logic [15:0] UTT_LO_FIRST  = 16'hDC00;
	localparam logic [15:0] UTT_LO_LAST   = 16'hDFFF;
	localparam logic [20:0] UTT_SUPP_BASE = 21'h10000;

	localparam logic [7:0] UTT_LEAD2 = 8'hC0;
	localparam logic [7:0] UTT_LEAD3 = 8'hE0;
	localparam logic [7:0] UTT_LEAD4 = 8'hF0;
	localparam logic [7:0] UTT_CONT  = 8'h80;
	localparam logic [5:0] UTT_MASK6 = 6'h3F;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        last_unit;
	} utt_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_end;
	} utt_out_t;

	// One queued unit of work: up to two code points and the string end flag
	typedef struct packed {
		logic [20:0] cp_a;
		logic [2:0]  len_a;
		logic [15:0] cp_b;
		logic [2:0]  len_b;
		logic        last;
	} utt_job_t;

	function automatic logic [2:0] utt_len(input logic [20:0] cp);
		logic [2:0] n;
		if (cp < 21'h80) begin
			n = 3'd1;
		end else if (cp < 21'h800) begin
			n = 3'd2;
		end else if (cp < UTT_SUPP_BASE) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	// Byte k of the len-byte UTF-8 sequence of cp
	function automatic logic [7:0] utt_byte(input logic [20:0] cp, input logic [2:0] len,
		input logic [2:0] k);
		logic [7:0] b;
		b = '0;
		case (len)
			3'd1: begin
				b = {1'b0, cp[6:0]};
			end
			3'd2: begin
				case (k)
					3'd0: b = UTT_LEAD2 | {3'b0, cp[10:6]};
					default: b = UTT_CONT | {2'b0, cp[5:0] & UTT_MASK6};
				endcase
			end
			3'd3: begin
				case (k)
					3'd0: b = UTT_LEAD3 | {4'b0, cp[15:12]};
					3'd1: b = UTT_CONT | {2'b0, cp[11:6] & UTT_MASK6};
					default: b = UTT_CONT | {2'b0, cp[5:0] & UTT_MASK6};
				endcase
			end
			default: begin
				case (k)
					3'd0: b = UTT_LEAD4 | {5'b0, cp[20:18]};
					3'd1: b = UTT_CONT | {2'b0, cp[17:12] & UTT_MASK6};
					3'd2: b = UTT_CONT | {2'b0, cp[11:6] & UTT_MASK6};
					default: b = UTT_CONT | {2'b0, cp[5:0] & UTT_MASK6};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

// File: rtl/utf16_to_utf8_transcoder_unit.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_unit
// UTF-16 code unit stream in, UTF-8 byte stream out, with surrogate pairing.
// ----------------------------------------------------------------------------
// The block emits one UTF-8 byte per clock cycle while the receiver keeps
// popping. A unit expands to one byte for ASCII, two or three for the rest
// of the basic plane, four for a surrogate pair (two units), and up to six
// when a held high surrogate is flushed ahead of the next unit. The output
// byte register is the limit on rate. Units are accepted back to back while
// the job queue (JOB_DEPTH entries) has room; full rises when it fills. A
// high surrogate that does not end its string is held inside the block and
// produces no bytes until the following unit arrives. A pushed unit passes
// through the job queue and the job register into the output byte register
// before its first byte shows on the result port. run_last marks the final
// byte caused by a unit and string_end the final byte of a string. No
// clearing is needed after reset.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_unit import utt_pkg::*; #(
	parameter int unsigned JOB_DEPTH = UTT_JOB_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  utt_in_t  unit_item,
	output logic     empty,
	input  logic     pop,
	output utt_out_t byte_item
);

	logic     accept;
	logic     job_wr;
	utt_job_t job_new;
	logic     job_avail;
	logic     job_take;
	utt_job_t job_head;

	// accept a unit whenever the queue has room
	assign accept = push && !full;

	utt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.unit_item (unit_item),
		.job_wr    (job_wr),
		.job       (job_new)
	);

	// decouple classification from byte emission
	utt_job_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_job_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (job_wr),
		.wr_job   (job_new),
		.full     (full),
		.rd       (job_take),
		.nonempty (job_avail),
		.rd_job   (job_head)
	);

	// serialise each job into bytes behind the output register
	utt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (job_avail),
		.job_head  (job_head),
		.job_take  (job_take),
		.empty     (empty),
		.pop       (pop),
		.byte_item (byte_item)
	);

endmodule

// File: rtl/utt_front.sv
// ----------------------------------------------------------------------------
// utt_front
// Accepts UTF-16 units, pairs surrogates and writes encoding jobs to the queue.
// ----------------------------------------------------------------------------
module utt_front import utt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  utt_in_t  unit_item,
	output logic     job_wr,
	output utt_job_t job
);

	logic       held_valid_q;
	logic [9:0] held_high_q;
	logic       held_valid_d;
	logic [9:0] held_high_d;
	logic       is_hi;
	logic       is_lo;
	logic [15:0] c;

	assign c     = unit_item.code_unit;
	assign is_hi = (c >= UTT_HI_FIRST) && (c <= UTT_HI_LAST);
	assign is_lo = (c >= UTT_LO_FIRST) && (c <= UTT_LO_LAST);

	always_comb begin
		job          = '0;
		job.last     = unit_item.last_unit;
		job_wr       = 1'b0;
		held_valid_d = held_valid_q;
		held_high_d  = held_high_q;
		if (accept) begin
			if (held_valid_q && is_lo) begin
				job.cp_a     = 21'({held_high_q, c[9:0]}) + UTT_SUPP_BASE;
				job.len_a    = 3'd4;
				job_wr       = 1'b1;
				held_valid_d = 1'b0;
			end else begin
				// flush the held surrogate on its own
				if (held_valid_q) begin
					job.cp_a  = 21'(UTT_HI_FIRST | {6'b0, held_high_q});
					job.len_a = 3'd3;
					job_wr    = 1'b1;
				end
				if (is_hi && !unit_item.last_unit) begin
					held_valid_d = 1'b1;
					held_high_d  = c[9:0];
				end else begin
					held_valid_d = 1'b0;
					job_wr       = 1'b1;
					if (held_valid_q) begin
						job.cp_b  = c;
						job.len_b = utt_len(21'(c));
					end else begin
						job.cp_a  = 21'(c);
						job.len_a = utt_len(21'(c));
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_high_q  <= '0;
		end else begin
			held_valid_q <= held_valid_d;
			held_high_q  <= held_high_d;
		end
	end

	a_last_never_held: assert property (@(posedge clk) disable iff (!arst_n)
		accept && unit_item.last_unit |=> !held_valid_q)
		else $error("last unit left a surrogate held");

endmodule

// File: rtl/utt_job_fifo.sv
// ----------------------------------------------------------------------------
// utt_job_fifo
// Short queue of encoding jobs between the front and back parts.
// ----------------------------------------------------------------------------
module utt_job_fifo import utt_pkg::*; #(
	parameter int unsigned DEPTH = UTT_JOB_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  utt_job_t wr_job,
	output logic     full,
	input  logic     rd,
	output logic     nonempty,
	output utt_job_t rd_job
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	utt_job_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && full) && !(rd && !nonempty))
		else $error("job queue written when full or read when empty");

endmodule

// File: rtl/utt_back.sv
// ----------------------------------------------------------------------------
// utt_back
// Takes queued jobs and emits their UTF-8 bytes one per cycle while popped.
// ----------------------------------------------------------------------------
module utt_back import utt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     job_avail,
	input  utt_job_t job_head,
	output logic     job_take,
	output logic     empty,
	input  logic     pop,
	output utt_out_t byte_item
);

	utt_job_t   job_q;
	logic       busy_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	utt_out_t   out_q;

	logic       advance;
	logic       is_final;
	logic       in_a;
	logic [2:0] total;
	logic [2:0] k;
	logic [2:0] seg_len;
	logic [20:0] seg_cp;
	utt_out_t   byte_next;

	assign total    = job_q.len_a + job_q.len_b;
	assign is_final = (idx_q == total - 3'd1);
	assign in_a     = (idx_q < job_q.len_a);
	assign k        = in_a ? idx_q : idx_q - job_q.len_a;
	assign seg_len  = in_a ? job_q.len_a : job_q.len_b;
	assign seg_cp   = in_a ? job_q.cp_a : 21'(job_q.cp_b);

	assign advance  = busy_q && (!out_valid_q || pop);
	assign job_take = job_avail && (!busy_q || (advance && is_final));

	always_comb begin
		byte_next.out_byte   = utt_byte(seg_cp, seg_len, k);
		byte_next.run_last   = is_final;
		byte_next.string_end = is_final && job_q.last;
	end

	assign empty     = !out_valid_q;
	assign byte_item = out_q;

	always_ff @(posedge clk) begin
		if (job_take) begin
			job_q <= job_head;
		end
		if (advance) begin
			out_q <= byte_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (job_take) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (advance && is_final) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q < total) && (job_q.len_a != 3'd0))
		else $error("byte index beyond the job");

	a_hold_unpopped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(out_q))
		else $error("waiting byte lost before it was taken");

endmodule

// File: bench/utf16_to_utf8_transcoder_unit_tb.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_unit_tb
// Self-checking bench for the UTF-16 to UTF-8 transcoder. A short table of
// code units covers the range edges, surrogate pairs, held surrogates that
// must be flushed and lone surrogates. A run of random strings follows. Every
// byte popped from the block is compared with the bytes the bench predicts.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import utt_pkg::*;

	localparam int RESET_CYCLES   = 9;
	localparam int RANDOM_UNITS   = 246;
	localparam int RX_HOLD_CYCLES = 200;
	// At most six bytes per unit
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 2000;

	// One row of the directed table. Where known is set, the bytes are typed in
	// (first byte in the top eight bits); otherwise the predictor supplies them.
	typedef struct packed {
		logic [15:0] code_unit;
		logic        last_unit;
		logic        known;
		logic [2:0]  known_count;
		logic [47:0] known_bytes;
	} stim_row_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     push = 1'b0;
	logic     full;
	utt_in_t  unit_item = '0;
	logic     empty;
	logic     pop = 1'b0;
	utt_out_t byte_item;

	// Predictor state: a high surrogate waiting for its partner
	logic       pending_high_valid = 1'b0;
	logic [9:0] pending_high_bits = '0;

	// Bytes caused by the latest unit, and every byte still owed by the block
	utt_out_t   unit_bytes [6];
	int         unit_byte_count = 0;
	utt_out_t   utf8_bytes_due [$];

	int         fail_count = 0;
	// Raised once by the sender; the receiver holds off and then marks it done
	bit         rx_hold_request = 1'b0;
	bit         rx_hold_done = 1'b0;

	stim_row_t directed_rows [0:23] = '{
		// range edges of the one, two and three byte forms
		'{16'h0000, 1'b0, 1'b1, 3'd1, 48'h00_00_00_00_00_00},
		'{16'h007F, 1'b1, 1'b1, 3'd1, 48'h7F_00_00_00_00_00},
		'{16'h0080, 1'b0, 1'b1, 3'd2, 48'hC2_80_00_00_00_00},
		'{16'h07FF, 1'b0, 1'b1, 3'd2, 48'hDF_BF_00_00_00_00},
		'{16'h0800, 1'b1, 1'b1, 3'd3, 48'hE0_A0_80_00_00_00},
		'{16'hFFFF, 1'b0, 1'b1, 3'd3, 48'hEF_BF_BF_00_00_00},
		// lowest and highest surrogate pairs; the held half gives nothing
		'{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0},
		'{16'hDC00, 1'b1, 1'b1, 3'd4, 48'hF0_90_80_80_00_00},
		'{16'hDBFF, 1'b0, 1'b1, 3'd0, 48'h0},
		'{16'hDFFF, 1'b0, 1'b1, 3'd4, 48'hF4_8F_BF_BF_00_00},
		// high surrogate that ends its string goes out alone
		'{16'hDBFF, 1'b1, 1'b1, 3'd3, 48'hED_AF_BF_00_00_00},
		// lone low surrogates
		'{16'hDC00, 1'b0, 1'b1, 3'd3, 48'hED_B0_80_00_00_00},
		'{16'hDFFF, 1'b1, 1'b1, 3'd3, 48'hED_BF_BF_00_00_00},
		// held surrogate flushed ahead of an ASCII unit
		'{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0},
		'{16'h0041, 1'b0, 1'b0, 3'd0, 48'h0},
		// held surrogate flushed and replaced by another, which goes out with a three byte unit as six bytes
		'{16'hDABC, 1'b0, 1'b1, 3'd0, 48'h0},
		'{16'hD955, 1'b0, 1'b0, 3'd0, 48'h0},
		'{16'hFFFF, 1'b1, 1'b0, 3'd0, 48'h0},
		// held surrogate flushed ahead of a high surrogate that ends the string
		'{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0},
		'{16'hDBFF, 1'b1, 1'b0, 3'd0, 48'h0},
		// held surrogate flushed ahead of a two byte unit
		'{16'hD800, 1'b0, 1'b1, 3'd0, 48'h0},
		'{16'h07FF, 1'b1, 1'b0, 3'd0, 48'h0},
		// alternating bit patterns
		'{16'hAAAA, 1'b0, 1'b0, 3'd0, 48'h0},
		'{16'h5555, 1'b1, 1'b0, 3'd0, 48'h0}
	};

	utf16_to_utf8_transcoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.unit_item (unit_item),
		.empty     (empty),
		.pop       (pop),
		.byte_item (byte_item)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	function automatic void add_byte(input logic [7:0] b);
		unit_bytes[unit_byte_count] = '{out_byte: b, run_last: 1'b0, string_end: 1'b0};
		unit_byte_count++;
	endfunction

	// Append the UTF-8 form of one code point, shortest form first
	function automatic void add_code_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			add_byte({1'b0, cp[6:0]});
		end else if (cp < 21'h800) begin
			add_byte(UTT_LEAD2 | {3'b0, cp[10:6]});
			add_byte(UTT_CONT | {2'b0, cp[5:0]});
		end else if (cp < UTT_SUPP_BASE) begin
			add_byte(UTT_LEAD3 | {4'b0, cp[15:12]});
			add_byte(UTT_CONT | {2'b0, cp[11:6]});
			add_byte(UTT_CONT | {2'b0, cp[5:0]});
		end else begin
			add_byte(UTT_LEAD4 | {5'b0, cp[20:18]});
			add_byte(UTT_CONT | {2'b0, cp[17:12]});
			add_byte(UTT_CONT | {2'b0, cp[11:6]});
			add_byte(UTT_CONT | {2'b0, cp[5:0]});
		end
	endfunction

	// Work out the bytes one accepted code unit causes and advance the state
	function automatic void predict_utf8(input logic [15:0] cu, input logic last_u);
		logic is_high;
		logic is_low;
		is_high = (cu >= UTT_HI_FIRST) && (cu <= UTT_HI_LAST);
		is_low = (cu >= UTT_LO_FIRST) && (cu <= UTT_LO_LAST);
		unit_byte_count = 0;
		if (pending_high_valid && is_low) begin
			// pair the held half with this one into a supplementary code point
			add_code_point(UTT_SUPP_BASE + {1'b0, pending_high_bits, cu[9:0]});
			pending_high_valid = 1'b0;
		end else begin
			if (pending_high_valid) begin
				add_code_point({5'b0, UTT_HI_FIRST | {6'b0, pending_high_bits}});
				pending_high_valid = 1'b0;
			end
			if (is_high && !last_u) begin
				pending_high_valid = 1'b1;
				pending_high_bits = cu[9:0];
			end else begin
				add_code_point({5'b0, cu});
			end
		end
		if (unit_byte_count > 0) begin
			unit_bytes[unit_byte_count - 1].run_last = 1'b1;
			unit_bytes[unit_byte_count - 1].string_end = last_u;
		end
	endfunction

	// Replace the predicted bytes with the ones typed into a table row
	function automatic void take_known_bytes(input stim_row_t row);
		unit_byte_count = row.known_count;
		for (int i = 0; i < unit_byte_count; i++) begin
			unit_bytes[i].out_byte = row.known_bytes[47 - 8 * i -: 8];
			unit_bytes[i].run_last = (i == unit_byte_count - 1);
			unit_bytes[i].string_end = (i == unit_byte_count - 1) && row.last_unit;
		end
	endfunction

	function automatic void queue_unit_bytes();
		for (int i = 0; i < unit_byte_count; i++) begin
			utf8_bytes_due = {utf8_bytes_due, unit_bytes[i]};
		end
	endfunction

	// Idle length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------
	// Offer one unit and return at the edge that takes it, push still high
	task automatic offer_unit(input logic [15:0] cu, input logic last_u);
		push <= 1'b1;
		unit_item <= '{code_unit: cu, last_unit: last_u};
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
	endtask

	task automatic sender_gap(input int cycles);
		if (cycles > 0) begin
			push <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Stop offering until every owed byte has come out, then let the pipe settle
	task automatic drain_pause();
		push <= 1'b0;
		while (utf8_bytes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		utt_in_t     str_units [$];
		logic [15:0] cu;
		int          str_len;
		int          pick;
		int          random_sent;
		bit          no_idle;
		bit          pause_done;

		random_sent = 0;
		pause_done = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (directed_rows[r]) begin
			offer_unit(directed_rows[r].code_unit, directed_rows[r].last_unit);
			predict_utf8(directed_rows[r].code_unit, directed_rows[r].last_unit);
			if (directed_rows[r].known) begin
				take_known_bytes(directed_rows[r]);
			end
			queue_unit_bytes();
			sender_gap(pick_gap());
		end
		drain_pause();

		// Random strings. The first ones go in back to back while the receiver
		// holds off, so the job queue fills and full must stall the sender.
		rx_hold_request = 1'b1;
		while (random_sent < RANDOM_UNITS) begin
			str_units.delete();
			str_len = $urandom_range(1, 12);
			while (str_units.size() < str_len) begin
				pick = $urandom_range(0, 99);
				if (pick < 30) begin
					cu = 16'($urandom_range(0, 16'h007F));
				end else if (pick < 45) begin
					cu = 16'($urandom_range(16'h0080, 16'h07FF));
				end else if (pick < 65) begin
					if ($urandom_range(0, 1) == 0) begin
						cu = 16'($urandom_range(16'h0800, 16'hD7FF));
					end else begin
						cu = 16'($urandom_range(16'hE000, 16'hFFFF));
					end
				end else if (pick < 83) begin
					// well-formed pair: high half now, low half below
					cu = 16'($urandom_range(UTT_HI_FIRST, UTT_HI_LAST));
					str_units = {str_units, utt_in_t'{code_unit: cu, last_unit: 1'b0}};
					cu = 16'($urandom_range(UTT_LO_FIRST, UTT_LO_LAST));
				end else if (pick < 88) begin
					cu = 16'($urandom_range(UTT_HI_FIRST, UTT_HI_LAST));
				end else if (pick < 93) begin
					cu = 16'($urandom_range(UTT_LO_FIRST, UTT_LO_LAST));
				end else begin
					cu = 16'($urandom);
				end
				str_units = {str_units, utt_in_t'{code_unit: cu, last_unit: 1'b0}};
			end
			str_units[str_units.size() - 1].last_unit = 1'b1;

			// some strings go through without any idling at all
			no_idle = ($urandom_range(0, 3) == 0);
			foreach (str_units[k]) begin
				offer_unit(str_units[k].code_unit, str_units[k].last_unit);
				predict_utf8(str_units[k].code_unit, str_units[k].last_unit);
				queue_unit_bytes();
				random_sent++;
				if (!no_idle && (!rx_hold_request || rx_hold_done)) begin
					sender_gap(pick_gap());
				end
			end

			// once, halfway through, wait for the block to run dry
			if (!pause_done && random_sent >= RANDOM_UNITS / 2) begin
				drain_pause();
				pause_done = 1'b1;
			end
		end
		drain_pause();

		if (fail_count == 0) begin
			$display("utf16_to_utf8_transcoder_unit regression: pass");
		end else begin
			$display("utf16_to_utf8_transcoder_unit regression: fail");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver side
	// ------------------------------------------------------------------------
	// Compare one popped byte with the oldest owed byte, field by field
	function automatic void check_byte(input utt_out_t got);
		utt_out_t want;
		if (utf8_bytes_due.size() == 0) begin
			$error("unexpected byte %h with run_last %b string_end %b",
				got.out_byte, got.run_last, got.string_end);
			fail_count++;
		end else begin
			want = utf8_bytes_due.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
				fail_count++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %b, got %b", want.run_last, got.run_last);
				fail_count++;
			end
			if (got.string_end !== want.string_end) begin
				$error("string_end: expected %b, got %b", want.string_end, got.string_end);
				fail_count++;
			end
		end
	endfunction

	initial begin : byte_sink
		int idle_left;
		int hold_left;
		int steady_left;

		idle_left = 0;
		hold_left = 0;
		steady_left = 0;
		forever begin
			@(posedge clk);
			// a transaction completes on this edge if pop was high and a byte waited
			if (pop && !empty) begin
				check_byte(byte_item);
			end
			if (hold_left > 0) begin
				// long hold-off; mark it done when it runs out
				hold_left--;
				if (hold_left == 0) begin
					rx_hold_done = 1'b1;
				end
				pop <= 1'b0;
			end else if (rx_hold_request && !rx_hold_done) begin
				hold_left = RX_HOLD_CYCLES;
				pop <= 1'b0;
			end else if (steady_left > 0) begin
				steady_left--;
				pop <= 1'b1;
			end else if (idle_left > 0) begin
				idle_left--;
				pop <= 1'b0;
			end else if ($urandom_range(0, 19) == 0) begin
				steady_left = 40;
				pop <= 1'b1;
			end else begin
				idle_left = pick_gap();
				if (idle_left > 0) begin
					idle_left--;
					pop <= 1'b0;
				end else begin
					pop <= 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run if neither side moves a transaction for too long
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int quiet_cycles;

		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("utf16_to_utf8_transcoder_unit regression: fail");
		$finish;
	end

endmodule
